/* design/csm_pkg.sv */
// csm_pkg: shared widths, register indexes and payload types for the
// circle sector mask scatter block; no dependencies
package csm_pkg;

   // limits of the layout
   localparam int MAX_BLOCK   = 1024;
   localparam int PIXEL_BYTES = 2;

   // field and datapath widths
   localparam int COORD_W   = 12;  // pixel_x, pixel_y
   localparam int BLOCK_W   = 11;  // block_size register
   localparam int RATIO_W   = 16;  // inner_ratio register, Q1.15
   localparam int DELTA_W   = 15;  // doubled centre-relative coordinates
   localparam int SQ_W      = 27;  // squared delta
   localparam int RB_W      = 27;  // inner_ratio * b
   localparam int RB2_W     = 2 * RB_W;
   localparam int BB_W      = 2 * BLOCK_W;
   localparam int R2_W      = SQ_W + 1;
   localparam int RING_SH   = 28;  // 2^28 scaling of the Q1.15 square
   localparam int ROW_W     = 14;  // shifted row or column, signed
   localparam int WIDTH_W   = 13;  // image width 3b in pixels
   localparam int LEN_W     = 26;  // buffer length in pixels, 12*b*b
   localparam int POS_W     = 28;  // linear pixel position, signed
   localparam int OFF_W     = 25;  // byte offset
   localparam int REGION_W  = 4;
   localparam int SECTOR_W  = 3;

   // configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = RATIO_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_SIZE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INNER_RATIO = 1'b1;

   localparam logic [BLOCK_W-1:0] BLOCK_SIZE_RESET  = 11'd64;
   localparam logic [RATIO_W-1:0] INNER_RATIO_RESET = 16'd16384;

   // region code for a pixel outside both rings
   localparam logic [REGION_W-1:0] REGION_NONE = 4'd12;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic                write_enable;
      logic [OFF_W-1:0]    byte_offset;
      logic [REGION_W-1:0] region;
      logic                overrun;
   } rsp_type;

   // squares stage, geometry to classifier
   typedef struct packed {
      logic [COORD_W-1:0]        x;
      logic [COORD_W-1:0]        y;
      logic [BLOCK_W-1:0]        b;
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic [SQ_W-1:0]           dx2;
      logic [SQ_W-1:0]           dy2;
      logic [RB2_W-1:0]          rb2;
      logic [BB_W-1:0]           bb;
   } sq_type;

   // shifted position, classifier to address unit
   typedef struct packed {
      logic [REGION_W-1:0]     region;
      logic                    hit;
      logic signed [ROW_W-1:0] row;
      logic signed [ROW_W-1:0] col;
      logic [WIDTH_W-1:0]      w;
      logic [LEN_W-1:0]        len_px;
   } shift_type;

endpackage

/* design/csm_geom.sv */
// csm_geom: two pipeline stages, centre-relative deltas then squares
// depends on csm_pkg
module csm_geom
   import csm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  req_type            in_data,
   input  logic [BLOCK_W-1:0] block_size,
   input  logic [RATIO_W-1:0] inner_ratio,
   output logic               out_valid,
   input  logic               out_ready,
   output sq_type             out_data
);

   typedef struct packed {
      logic [COORD_W-1:0]        x;
      logic [COORD_W-1:0]        y;
      logic [BLOCK_W-1:0]        b;
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic [RB_W-1:0]           rb;
   } delta_type;

   logic               v1_ff, v1_in, v2_ff, v2_in;
   logic               rdy1, rdy2;
   logic [BLOCK_W-1:0] b_sat;
   delta_type          d1_ff, d1_in;
   sq_type             s2_ff, s2_in;

   logic signed [2*DELTA_W-1:0] dx_sq, dy_sq;

   assign rdy2     = !v2_ff || out_ready;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // stage 1: saturate b, doubled deltas, ratio times b
   always_comb begin
      if (int'(block_size) > MAX_BLOCK) begin
         b_sat = BLOCK_W'(MAX_BLOCK);
      end else begin
         b_sat = block_size;
      end
      d1_in.x  = in_data.pixel_x;
      d1_in.y  = in_data.pixel_y;
      d1_in.b  = b_sat;
      d1_in.dx = $signed({2'b00, in_data.pixel_x, 1'b0})
               - ($signed({3'b000, b_sat, 1'b0}) + $signed({4'b0000, b_sat}));
      d1_in.dy = $signed({2'b00, b_sat, 2'b00}) - $signed({2'b00, in_data.pixel_y, 1'b0});
      d1_in.rb = RB_W'(inner_ratio) * RB_W'(b_sat);
      v1_in    = rdy1 ? in_valid : v1_ff;
   end

   // stage 2: squares
   assign dx_sq = (2*DELTA_W)'(d1_ff.dx) * (2*DELTA_W)'(d1_ff.dx);
   assign dy_sq = (2*DELTA_W)'(d1_ff.dy) * (2*DELTA_W)'(d1_ff.dy);

   always_comb begin
      s2_in.x   = d1_ff.x;
      s2_in.y   = d1_ff.y;
      s2_in.b   = d1_ff.b;
      s2_in.dx  = d1_ff.dx;
      s2_in.dy  = d1_ff.dy;
      s2_in.dx2 = dx_sq[SQ_W-1:0];
      s2_in.dy2 = dy_sq[SQ_W-1:0];
      s2_in.rb2 = RB2_W'(d1_ff.rb) * RB2_W'(d1_ff.rb);
      s2_in.bb  = BB_W'(d1_ff.b) * BB_W'(d1_ff.b);
      v2_in     = rdy2 ? v1_ff : v2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         d1_ff <= d1_in;
      end
      if (rdy2 && v1_ff) begin
         s2_ff <= s2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = s2_ff;

endmodule

/* design/csm_classify.sv */
// csm_classify: two pipeline stages, ring and sector tests then block
// choice and shift; depends on csm_pkg
module csm_classify
   import csm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  sq_type    in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output shift_type out_data
);

   localparam logic [SECTOR_W-1:0] SEC_0   = 3'd0;
   localparam logic [SECTOR_W-1:0] SEC_60  = 3'd1;
   localparam logic [SECTOR_W-1:0] SEC_120 = 3'd2;
   localparam logic [SECTOR_W-1:0] SEC_180 = 3'd3;
   localparam logic [SECTOR_W-1:0] SEC_240 = 3'd4;
   localparam logic [SECTOR_W-1:0] SEC_300 = 3'd5;

   typedef struct packed {
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic [BLOCK_W-1:0]  b;
      logic                inner;
      logic                hit;
      logic [SECTOR_W-1:0] sector;
      logic [BB_W-1:0]     bb;
   } ring_type;

   // sector includes its lower edge; the centre counts as sector 0
   function automatic logic [SECTOR_W-1:0] pick_sector(
      input logic signed [DELTA_W-1:0] dx,
      input logic signed [DELTA_W-1:0] dy,
      input logic                      narrow
   );
      logic [SECTOR_W-1:0] s;
      priority if (dy == 0 && !dx[DELTA_W-1]) begin
         s = SEC_0;
      end else if (dy > 0) begin
         priority if (dx > 0 && narrow) begin
            s = SEC_0;
         end else if (dx < 0 && narrow) begin
            s = SEC_120;
         end else begin
            s = SEC_60;
         end
      end else if (dx < 0 && narrow) begin
         s = SEC_180;
      end else if (dx > 0 && narrow) begin
         s = SEC_300;
      end else begin
         s = SEC_240;
      end
      return s;
   endfunction

   logic            v3_ff, v3_in, v4_ff, v4_in;
   logic            rdy3, rdy4;
   logic [R2_W-1:0] r2, dx2x3;
   logic            narrow, inner, outer;
   ring_type        r3_ff, r3_in;
   shift_type       s4_ff, s4_in;

   logic signed [ROW_W-1:0] half_ext, b_ext, x_ext, y_ext;
   logic [REGION_W-1:0]     blk_inner, blk_outer;
   logic                    tx_pos, tx_neg, ty_neg;

   assign rdy4     = !v4_ff || out_ready;
   assign rdy3     = !v3_ff || rdy4;
   assign in_ready = rdy3;

   // stage 3: squared radius against both rings, 60 degree edge test
   always_comb begin
      r2     = R2_W'(in_data.dx2) + R2_W'(in_data.dy2);
      dx2x3  = R2_W'(in_data.dx2) + {in_data.dx2, 1'b0};
      narrow = R2_W'(in_data.dy2) < dx2x3;
      inner  = {r2, RING_SH'(0)} <= (R2_W + RING_SH)'(in_data.rb2);
      outer  = !inner && (r2 <= R2_W'({in_data.bb, 2'b00}));
      r3_in.x      = in_data.x;
      r3_in.y      = in_data.y;
      r3_in.b      = in_data.b;
      r3_in.inner  = inner;
      r3_in.hit    = inner || outer;
      r3_in.sector = pick_sector(in_data.dx, in_data.dy, narrow);
      r3_in.bb     = in_data.bb;
      v3_in        = rdy3 ? in_valid : v3_ff;
   end

   // stage 4: block number and shift from the layout
   always_comb begin
      unique case (r3_ff.sector)
         SEC_0: begin
            blk_inner = 4'd4;  blk_outer = 4'd5;
            tx_pos = 1'b1; tx_neg = 1'b0; ty_neg = 1'b1;
         end
         SEC_60: begin
            blk_inner = 4'd3;  blk_outer = 4'd0;
            tx_pos = 1'b0; tx_neg = 1'b0; ty_neg = 1'b1;
         end
         SEC_120: begin
            blk_inner = 4'd2;  blk_outer = 4'd1;
            tx_pos = 1'b0; tx_neg = 1'b1; ty_neg = 1'b1;
         end
         SEC_180: begin
            blk_inner = 4'd7;  blk_outer = 4'd6;
            tx_pos = 1'b0; tx_neg = 1'b1; ty_neg = 1'b0;
         end
         SEC_240: begin
            blk_inner = 4'd8;  blk_outer = 4'd11;
            tx_pos = 1'b0; tx_neg = 1'b0; ty_neg = 1'b0;
         end
         SEC_300: begin
            blk_inner = 4'd9;  blk_outer = 4'd10;
            tx_pos = 1'b1; tx_neg = 1'b0; ty_neg = 1'b0;
         end
         default: begin
            blk_inner = REGION_NONE; blk_outer = REGION_NONE;
            tx_pos = 1'b0; tx_neg = 1'b0; ty_neg = 1'b0;
         end
      endcase

      half_ext = $signed({4'b0000, r3_ff.b[BLOCK_W-1:1]});
      b_ext    = $signed({3'b000, r3_ff.b});
      x_ext    = $signed({2'b00, r3_ff.x});
      y_ext    = $signed({2'b00, r3_ff.y});

      if (!r3_ff.hit) begin
         s4_in.region = REGION_NONE;
      end else if (r3_ff.inner) begin
         s4_in.region = blk_inner;
      end else begin
         s4_in.region = blk_outer;
      end
      s4_in.hit = r3_ff.hit;

      if (tx_pos) begin
         s4_in.col = x_ext + half_ext;
      end else if (tx_neg) begin
         s4_in.col = x_ext - half_ext;
      end else begin
         s4_in.col = x_ext;
      end

      // inner ring keeps its row
      if (r3_ff.inner) begin
         s4_in.row = y_ext;
      end else if (ty_neg) begin
         s4_in.row = y_ext - b_ext;
      end else begin
         s4_in.row = y_ext + b_ext;
      end

      s4_in.w      = WIDTH_W'({r3_ff.b, 1'b0}) + WIDTH_W'(r3_ff.b);
      s4_in.len_px = LEN_W'({r3_ff.bb, 3'b000}) + LEN_W'({r3_ff.bb, 2'b00});
      v4_in        = rdy4 ? v3_ff : v4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3 && in_valid) begin
         r3_ff <= r3_in;
      end
      if (rdy4 && v3_ff) begin
         s4_ff <= s4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_data  = s4_ff;

endmodule

/* design/csm_addr.sv */
// csm_addr: two pipeline stages, linear position then buffer check and
// the output register; depends on csm_pkg
module csm_addr
   import csm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  shift_type in_data,
   output logic      out_valid,
   input  logic      out_stall,
   output rsp_type   out_data
);

   typedef struct packed {
      logic [REGION_W-1:0]     region;
      logic                    hit;
      logic signed [POS_W-1:0] pos;
      logic [LEN_W-1:0]        len_px;
   } pos_type;

   logic                  v5_ff, v5_in, v6_ff, v6_in;
   logic                  rdy5, rdy6;
   logic                  in_range;
   logic [POS_W-2:0]      pos_bytes;
   pos_type               p5_ff, p5_in;
   rsp_type               o6_ff, o6_in;

   logic signed [POS_W-1:0] pos_prod;

   assign rdy6     = !v6_ff || !out_stall;
   assign rdy5     = !v5_ff || rdy6;
   assign in_ready = rdy5;

   // stage 5: row times width plus column
   assign pos_prod = POS_W'(in_data.row) * POS_W'($signed({1'b0, in_data.w}));

   always_comb begin
      p5_in.region = in_data.region;
      p5_in.hit    = in_data.hit;
      p5_in.pos    = pos_prod + POS_W'(in_data.col);
      p5_in.len_px = in_data.len_px;
      v5_in        = rdy5 ? in_valid : v5_ff;
   end

   // stage 6: bounds check against the buffer, byte offset
   always_comb begin
      in_range  = !p5_ff.pos[POS_W-1]
               && (p5_ff.pos[POS_W-2:0] < (POS_W-1)'(p5_ff.len_px));
      pos_bytes = p5_ff.pos[POS_W-2:0] * (POS_W-1)'(PIXEL_BYTES);
      o6_in.write_enable = p5_ff.hit && in_range;
      o6_in.overrun      = p5_ff.hit && !in_range;
      o6_in.region       = p5_ff.region;
      if (p5_ff.hit && in_range) begin
         o6_in.byte_offset = pos_bytes[OFF_W-1:0];
      end else begin
         o6_in.byte_offset = '0;
      end
      v6_in = rdy6 ? v5_ff : v6_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v5_ff <= v5_in;
         v6_ff <= v6_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5 && in_valid) begin
         p5_ff <= p5_in;
      end
      if (rdy6 && v5_ff) begin
         o6_ff <= o6_in;
      end
   end

   assign out_valid = v6_ff;
   assign out_data  = o6_ff;

endmodule

/* design/circle_sector_mask_scatter_top.sv */
// circle_sector_mask_scatter_top: mask pixel scatter for a 3b by 4b YUYV image
// depends on csm_pkg, csm_geom, csm_classify, csm_addr
//
//   channel   ports                          payload    direction
//   request   req_valid, req_stall, req_data req_type   in
//   response  rsp_valid, rsp_stall, rsp_data rsp_type   out
//   config    csr_write, csr_index, csr_data 16 bits    in
//
// one request per clock sustained while rsp_stall is low; six register stages
// (deltas, squares, ring test, shift, position multiply, bounds check with the
// output register), and rsp_valid rises once a request has passed all six
// reset clears every stage valid and loads block_size 64, inner_ratio 16384
// a stalled response holds its stage; earlier stages keep filling bubbles, and
// req_stall rises only once every stage holds a request
module circle_sector_mask_scatter_top
   import csm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   // configuration writes
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // configuration registers
   logic [BLOCK_W-1:0] block_size_ff, block_size_in;
   logic [RATIO_W-1:0] inner_ratio_ff, inner_ratio_in;

   // stage links
   logic      geom_ready;
   logic      sq_valid, sq_ready;
   sq_type    sq_data;
   logic      shift_valid, shift_ready;
   shift_type shift_data;

   always_comb begin
      block_size_in  = block_size_ff;
      inner_ratio_in = inner_ratio_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_BLOCK_SIZE:  block_size_in  = csr_data[BLOCK_W-1:0];
            CSR_INNER_RATIO: inner_ratio_in = csr_data[RATIO_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff  <= BLOCK_SIZE_RESET;
         inner_ratio_ff <= INNER_RATIO_RESET;
      end else begin
         block_size_ff  <= block_size_in;
         inner_ratio_ff <= inner_ratio_in;
      end
   end

   // doubled deltas about the centre, then their squares
   csm_geom u_geom (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (geom_ready),
      .in_data     (req_data),
      .block_size  (block_size_ff),
      .inner_ratio (inner_ratio_ff),
      .out_valid   (sq_valid),
      .out_ready   (sq_ready),
      .out_data    (sq_data)
   );

   // ring and sector, then block number and shifted row and column
   csm_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_ready  (sq_ready),
      .in_data   (sq_data),
      .out_valid (shift_valid),
      .out_ready (shift_ready),
      .out_data  (shift_data)
   );

   // linear position, buffer check, response register
   csm_addr u_addr (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (shift_valid),
      .in_ready  (shift_ready),
      .in_data   (shift_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign req_stall = !geom_ready;

endmodule

/* design/csm_checker.sv */
// csm_checker: port-level checks on the mask scatter top level, with its bind
// depends on csm_pkg and circle_sector_mask_scatter_top
module csm_checker
   import csm_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled response stays and holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // after reset the pipeline is empty and takes requests
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // a ring hit either writes or reports overrun, never both
   a_hit_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.region != REGION_NONE
      |-> rsp_data.write_enable != rsp_data.overrun)
      else $error("hit without a single outcome");

   // a miss or a refused write carries a zero offset, and a miss reports no overrun
   a_miss_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.write_enable
      |-> rsp_data.byte_offset == '0
          && (rsp_data.region != REGION_NONE || !rsp_data.overrun))
      else $error("response without write carries data");

endmodule

bind circle_sector_mask_scatter_top csm_checker u_csm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* sim/testbench.sv */
// testbench for circle_sector_mask_scatter_top: directed and random pixel requests
// checked against an in-bench model of the sector, ring and offset logic
// depends on csm_pkg and the block's rtl
module testbench;
   import csm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // register stages between a request and its response
   localparam int LATENCY = 6;

   // the six 60 degree sectors, counter-clockwise from the positive x axis
   typedef enum int {
      SEC_NE = 0,   // 0 to 60
      SEC_N  = 1,   // 60 to 120
      SEC_NW = 2,   // 120 to 180
      SEC_SW = 3,   // 180 to 240
      SEC_S  = 4,   // 240 to 300
      SEC_SE = 5    // 300 to 360
   } sector_type;

   // scoreboard: keeps its own copy of the registers, predicts each request's
   // mask write and compares responses in order
   class scatter_scoreboard;
      typedef struct {
         req_type pixel;
         rsp_type want;
      } pending_write_type;

      pending_write_type pending_writes[$];
      logic [BLOCK_W-1:0] block_size;
      logic [RATIO_W-1:0] inner_ratio;
      int unsigned mismatch_count;
      int unsigned checked_count;
      int unsigned written_count;
      int unsigned overrun_count;
      int unsigned miss_count;

      function new();
         block_size     = BLOCK_SIZE_RESET;
         inner_ratio    = INNER_RATIO_RESET;
         mismatch_count = 0;
         checked_count  = 0;
         written_count  = 0;
         overrun_count  = 0;
         miss_count     = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         if (index == CSR_BLOCK_SIZE)
            block_size = data[BLOCK_W-1:0];
         else if (index == CSR_INNER_RATIO)
            inner_ratio = data[RATIO_W-1:0];
      endfunction

      function int unsigned pending();
         return pending_writes.size();
      endfunction

      // lower edge belongs to the sector; the centre counts as angle 0
      function sector_type sector_of(longint dx, longint dy);
         longint unsigned dy2;
         longint unsigned dx2x3;
         bit narrow;
         dy2    = dy * dy;
         dx2x3  = 3 * dx * dx;
         narrow = dy2 < dx2x3;
         if (dy == 0 && dx >= 0)
            return SEC_NE;
         if (dy > 0) begin
            if (dx > 0 && narrow)
               return SEC_NE;
            if (dx < 0 && narrow)
               return SEC_NW;
            return SEC_N;
         end
         if (dx < 0 && narrow)
            return SEC_SW;
         if (dx > 0 && narrow)
            return SEC_SE;
         return SEC_S;
      endfunction

      function logic [REGION_W-1:0] block_of(sector_type s, bit in_inner);
         case (s)
            SEC_NE: return in_inner ? 4'd4 : 4'd5;
            SEC_N:  return in_inner ? 4'd3 : 4'd0;
            SEC_NW: return in_inner ? 4'd2 : 4'd1;
            SEC_SW: return in_inner ? 4'd7 : 4'd6;
            SEC_S:  return in_inner ? 4'd8 : 4'd11;
            default: return in_inner ? 4'd9 : 4'd10;
         endcase
      endfunction

      function rsp_type predict_scatter(req_type px);
         longint b, x, y, dx, dy, tx, ty, w, pos, len, half;
         longint unsigned r2, ub, ur;
         bit in_inner, in_outer;
         sector_type s;
         rsp_type res;
         b  = (block_size > MAX_BLOCK) ? longint'(MAX_BLOCK) : longint'(block_size);
         x  = px.pixel_x;
         y  = px.pixel_y;
         dx = 2 * x - 3 * b;
         dy = 4 * b - 2 * y;
         r2 = dx * dx + dy * dy;
         ub = b;
         ur = inner_ratio;
         in_inner = (r2 << RING_SH) <= ur * ur * ub * ub;
         in_outer = !in_inner && r2 <= 4 * ub * ub;
         res = '0;
         res.region = REGION_NONE;
         if (in_inner || in_outer) begin
            s    = sector_of(dx, dy);
            half = b / 2;
            if (s == SEC_NE || s == SEC_SE)
               tx = half;
            else if (s == SEC_N || s == SEC_S)
               tx = 0;
            else
               tx = -half;
            if (in_inner)
               ty = 0;
            else if (s == SEC_NE || s == SEC_N || s == SEC_NW)
               ty = -b;
            else
               ty = b;
            res.region = block_of(s, in_inner);
            w   = 3 * b;
            pos = ((y + ty) * w + x + tx) * PIXEL_BYTES;
            len = w * 4 * b * PIXEL_BYTES;
            if (pos >= 0 && pos < len) begin
               res.write_enable = 1'b1;
               res.byte_offset  = OFF_W'(pos);
            end else begin
               res.overrun = 1'b1;
            end
         end
         return res;
      endfunction

      function void note_request(req_type px);
         pending_write_type entry;
         entry.pixel = px;
         entry.want  = predict_scatter(px);
         pending_writes.push_back(entry);
      endfunction

      task report(string what);
         if (mismatch_count < 100)
            $display("mismatch at %0t: %s", $time, what);
         mismatch_count++;
      endtask

      task check_response(rsp_type got);
         pending_write_type entry;
         if (pending_writes.size() == 0) begin
            report("response with no request outstanding");
            return;
         end
         entry = pending_writes.pop_front();
         checked_count++;
         if (entry.want.overrun)
            overrun_count++;
         else if (entry.want.write_enable)
            written_count++;
         else
            miss_count++;
         if (got.write_enable !== entry.want.write_enable)
            report($sformatf("pixel (%0d,%0d) write_enable %0b, expected %0b",
                   entry.pixel.pixel_x, entry.pixel.pixel_y,
                   got.write_enable, entry.want.write_enable));
         if (got.byte_offset !== entry.want.byte_offset)
            report($sformatf("pixel (%0d,%0d) byte_offset %0d, expected %0d",
                   entry.pixel.pixel_x, entry.pixel.pixel_y,
                   got.byte_offset, entry.want.byte_offset));
         if (got.region !== entry.want.region)
            report($sformatf("pixel (%0d,%0d) region %0d, expected %0d",
                   entry.pixel.pixel_x, entry.pixel.pixel_y,
                   got.region, entry.want.region));
         if (got.overrun !== entry.want.overrun)
            report($sformatf("pixel (%0d,%0d) overrun %0b, expected %0b",
                   entry.pixel.pixel_x, entry.pixel.pixel_y,
                   got.overrun, entry.want.overrun));
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_data;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   scatter_scoreboard board;
   bit                calm;          // no idling on either side while set
   int unsigned       setting_count;

   circle_sector_mask_scatter_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // idle with a chance of about 7 in a hundred at each draw, except in a calm stretch
   function automatic bit take_gap();
      return !calm && ($urandom_range(99) < 7);
   endfunction

   // response side: stall decided at each falling edge
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= take_gap();
      end
   end

   // responses are sampled at the rising edge, before the block updates
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         board.check_response(rsp_data);
   end

   // one request: optional idle gap, then hold valid and payload until taken
   task automatic send_pixel(req_type px);
      @(negedge clock);
      while (take_gap()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      board.note_request(px);
   endtask

   // lower valid and wait for every outstanding request to come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(negedge clock);
      csr_write <= 1'b0;
      board.set_register(index, data);
   endtask

   function automatic req_type make_pixel(int unsigned x, int unsigned y);
      req_type px;
      px.pixel_x = COORD_W'(x);
      px.pixel_y = COORD_W'(y);
      return px;
   endfunction

   // mostly pixels near the circle or inside the image, some anywhere in the
   // 12-bit field; eb is the block edge after saturation
   function automatic req_type random_pixel(int unsigned eb);
      int unsigned mode;
      mode = $urandom_range(99);
      if (mode < 15)
         return make_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
      if (eb == 0)
         return make_pixel($urandom_range(0, 3), $urandom_range(0, 3));
      if (mode < 55)
         return make_pixel($urandom_range(0, 3 * eb - 1), $urandom_range(0, 4 * eb - 1));
      return make_pixel($urandom_range(eb / 2, (5 * eb) / 2), $urandom_range(eb, 3 * eb));
   endfunction

   // new register setting on an idle block, then a burst of random requests
   task automatic run_phase(int unsigned bs, int unsigned ratio, int unsigned count, bit quiet);
      int unsigned eb;
      logic [CSR_DATA_W-1:0] bs_word;
      eb = (bs > MAX_BLOCK) ? MAX_BLOCK : bs;
      drain();
      // junk above the 11 register bits must be dropped by the block
      bs_word = CSR_DATA_W'(bs) | (CSR_DATA_W'($urandom_range(0, 31)) << BLOCK_W);
      write_register(CSR_BLOCK_SIZE, bs_word);
      write_register(CSR_INNER_RATIO, CSR_DATA_W'(ratio));
      setting_count++;
      calm = quiet;
      repeat (count)
         send_pixel(random_pixel(eb));
      calm = 1'b0;
   endtask

   // main sequence
   initial begin : stimulus
      req_type directed [$];
      board         = new();
      calm          = 1'b0;
      setting_count = 1;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_write <= 1'b0;
      csr_index <= CSR_BLOCK_SIZE;
      csr_data  <= '0;
      repeat (6)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset setting, b = 64 and ratio one half: image 192 by 256
      directed.push_back(make_pixel(96, 128));     // centre, angle 0
      directed.push_back(make_pixel(90, 128));     // angle 180, inner
      directed.push_back(make_pixel(106, 126));    // inner, one per sector
      directed.push_back(make_pixel(96, 118));
      directed.push_back(make_pixel(86, 126));
      directed.push_back(make_pixel(86, 130));
      directed.push_back(make_pixel(96, 138));
      directed.push_back(make_pixel(106, 130));
      directed.push_back(make_pixel(146, 126));    // outer, one per sector
      directed.push_back(make_pixel(96, 78));
      directed.push_back(make_pixel(46, 126));
      directed.push_back(make_pixel(46, 130));
      directed.push_back(make_pixel(96, 178));
      directed.push_back(make_pixel(146, 130));
      directed.push_back(make_pixel(146, 128));    // outer on angle 0
      directed.push_back(make_pixel(128, 128));    // exactly on the inner radius
      directed.push_back(make_pixel(129, 128));    // just past it
      directed.push_back(make_pixel(160, 128));    // outer radius, shift wraps the row
      directed.push_back(make_pixel(161, 128));    // just outside both rings
      directed.push_back(make_pixel(96, 192));     // bottom shift runs past the buffer
      directed.push_back(make_pixel(0, 0));        // field extremes
      directed.push_back(make_pixel(4095, 4095));
      directed.push_back(make_pixel(0, 4095));
      directed.push_back(make_pixel(4095, 0));
      foreach (directed[i])
         send_pixel(directed[i]);
      repeat (170)
         send_pixel(random_pixel(64));

      run_phase(4, 16384, 170, 1'b0);        // smallest legal block
      run_phase(1024, 65535, 170, 1'b1);     // largest block, ratio near two, no idling
      run_phase(2047, 32768, 170, 1'b0);     // saturating block, ratio exactly one
      run_phase(0, 20000, 170, 1'b0);        // empty buffer: every hit overruns
      run_phase(1, 40000, 170, 1'b0);
      run_phase(3, 1, 170, 1'b0);
      run_phase(1024, 0, 170, 1'b0);         // inner ring shrinks to the centre point alone
      run_phase(5, 32767, 170, 1'b0);        // odd block, half shift rounds down
      repeat (3)
         run_phase($urandom_range(4, MAX_BLOCK), $urandom_range(0, 65535), 170, 1'b0);

      // wait out the pipeline and catch any stray response
      drain();
      repeat (3 * LATENCY)
         @(posedge clock);

      $display("summary: %0d pixel requests over %0d register settings", board.checked_count,
               setting_count);
      $display("summary: %0d written, %0d overrun, %0d outside both rings",
               board.written_count, board.overrun_count, board.miss_count);
      if (board.mismatch_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   // hard stop well past the slowest correct run
   initial begin : watchdog
      #400000;
      $display("testbench: errors");
      $finish;
   end

endmodule

/* filelist.f */
design/csm_pkg.sv
design/csm_geom.sv
design/csm_classify.sv
design/csm_addr.sv
design/circle_sector_mask_scatter_top.sv
design/csm_checker.sv
sim/testbench.sv
